// ===== src/plcap_pkg.sv =====
// plcap_pkg: shared types, constants and mnemonic tables for the address parser
`default_nettype none
package plcap_pkg;

  // default width of the internal decimal accumulators
  localparam int NumberWidthDefault = 16;
  // width of the number fields in a result
  localparam int OutNumWidth = 16;
  localparam int MnemCount = 7;

  // parse modes
  typedef enum logic [2:0] {
    MODE_NORMAL      = 3'd0,
    MODE_FILE_FIRST  = 3'd1,
    MODE_FILE_DIGITS = 3'd2,
    MODE_ELEM_FIRST  = 3'd3,
    MODE_ELEM_DIGITS = 3'd4,
    MODE_TAIL_FIRST  = 3'd5,
    MODE_TAIL_DIGITS = 3'd6,
    MODE_TAIL_REST   = 3'd7
  } mode_t;

  // file type codes
  localparam logic [7:0] TYPE_NONE   = 8'h00;
  localparam logic [7:0] TYPE_OUTPUT = 8'h8b;
  localparam logic [7:0] TYPE_INPUT  = 8'h8c;
  localparam logic [7:0] TYPE_STATUS = 8'h84;
  localparam logic [7:0] TYPE_BIT    = 8'h85;
  localparam logic [7:0] TYPE_TIMER  = 8'h86;
  localparam logic [7:0] TYPE_COUNT  = 8'h87;
  localparam logic [7:0] TYPE_CTRL   = 8'h88;
  localparam logic [7:0] TYPE_INT    = 8'h89;
  localparam logic [7:0] TYPE_FLOAT  = 8'h8a;

  // element sizes in bytes
  localparam logic [2:0] SIZE_NONE  = 3'd0;
  localparam logic [2:0] SIZE_WORD  = 3'd2;
  localparam logic [2:0] SIZE_FLOAT = 3'd4;

  // one result request
  typedef struct packed {
    logic [7:0]             file_type;
    logic [OutNumWidth-1:0] file_number;
    logic [OutNumWidth-1:0] element_number;
    logic [OutNumWidth-1:0] sub_element_number;
    logic [2:0]             data_size;
  } result_t;

  // mnemonic text, lower case, zero past its end
  function automatic logic [7:0] mnem_char(input logic [2:0] idx, input logic [1:0] pos);
    logic [23:0] word;
    unique case (idx)
      3'd0:    word = {8'h61, 8'h63, 8'h63};  // acc
      3'd1:    word = {8'h70, 8'h72, 8'h65};  // pre
      3'd2:    word = {8'h6c, 8'h65, 8'h6e};  // len
      3'd3:    word = {8'h70, 8'h6f, 8'h73};  // pos
      3'd4:    word = {8'h65, 8'h6e, 8'h00};  // en
      3'd5:    word = {8'h74, 8'h74, 8'h00};  // tt
      3'd6:    word = {8'h64, 8'h6e, 8'h00};  // dn
      default: word = 24'h0;
    endcase
    case (pos)
      2'd0:    return word[23:16];
      2'd1:    return word[15:8];
      2'd2:    return word[7:0];
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [1:0] mnem_len(input logic [2:0] idx);
    return (idx < 3'd4) ? 2'd3 : 2'd2;
  endfunction

  function automatic logic [3:0] mnem_code(input logic [2:0] idx);
    unique case (idx)
      3'd0:    return 4'd2;
      3'd1:    return 4'd1;
      3'd2:    return 4'd1;
      3'd3:    return 4'd2;
      3'd4:    return 4'd13;
      3'd5:    return 4'd14;
      3'd6:    return 4'd15;
      default: return 4'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== src/plcap_if.sv =====
// plcap_in_if and plcap_out_if: character and result channels
`default_nettype none
interface plcap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_text;

  modport source (output valid, output character, output end_of_text, input ready);
  modport sink   (input valid, input character, input end_of_text, output ready);
endinterface

interface plcap_out_if;
  logic                            valid;
  logic                            ready;
  logic [7:0]                      file_type;
  logic [plcap_pkg::OutNumWidth-1:0] file_number;
  logic [plcap_pkg::OutNumWidth-1:0] element_number;
  logic [plcap_pkg::OutNumWidth-1:0] sub_element_number;
  logic [2:0]                      data_size;

  modport source (output valid, output file_type, output file_number,
                  output element_number, output sub_element_number,
                  output data_size, input ready);
  modport sink   (input valid, input file_type, input file_number,
                  input element_number, input sub_element_number,
                  input data_size, output ready);
endinterface
`default_nettype wire

// ===== src/plc_address_text_parser.sv =====
// plc_address_text_parser: character-serial parser for PLC data-table addresses
//
// Takes one address character per request (for example N7:0/5 or T4:2.acc) and
// returns one result request when the character flagged end_of_text is taken:
// file type code, file number, element number, sub-element number or mnemonic
// code, and element size. The parse state updates in the cycle a character is
// accepted, so characters may arrive every clock while in_chan.ready is high; the
// result is registered in the output register, or in the skid register while the
// output register holds an untaken result. This two-entry buffer lets parsing go
// on while a result waits; in_chan.ready drops only while both hold results
// not yet taken. After each result the parser is reset for the next address.
`default_nettype none
module plc_address_text_parser #(
  parameter int NUMBER_WIDTH = plcap_pkg::NumberWidthDefault
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  plcap_in_if.sink          in_chan,
  plcap_out_if.source       out_chan
);

  localparam int NW = NUMBER_WIDTH;
  localparam int OW = plcap_pkg::OutNumWidth;

  // decimal multiply-add by ten with saturation
  function automatic logic [NW-1:0] accumulate(input logic [NW-1:0] v, input logic [3:0] d);
    logic [NW+3:0] n;
    n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{NW{1'b0}}, d};
    return (n[NW+3:NW] != 4'b0) ? {NW{1'b1}} : n[NW-1:0];
  endfunction

  // fit an accumulator to the result width
  function automatic logic [OW-1:0] to_out(input logic [NW-1:0] v);
    logic [NW+OW-1:0] ext;
    ext = {{OW{1'b0}}, v};
    return ext[OW-1:0];
  endfunction

  // parse state
  logic [7:0]        type_code_r,   type_code_nxt;
  logic [NW-1:0]     file_val_r,    file_val_nxt;
  logic [NW-1:0]     elem_val_r,    elem_val_nxt;
  logic [2:0]        size_r,        size_nxt;
  plcap_pkg::mode_t  mode_r,        mode_nxt;
  logic [NW-1:0]     tail_val_r,    tail_val_nxt;
  logic              tail_dig_r,    tail_dig_nxt;
  logic [6:0]        match_r,       match_nxt;
  logic [2:0]        tail_len_r,    tail_len_nxt;

  // result buffer
  logic                 out_valid_r, skid_valid_r;
  plcap_pkg::result_t   out_data_r,  skid_data_r;
  plcap_pkg::result_t   result;

  logic       accept, push, pop;
  logic [7:0] ch, lc;
  logic       dig;
  logic [3:0] dval;
  logic       dispatch_en;
  logic [OW-1:0] sub;

  assign in_chan.ready = !skid_valid_r;
  assign accept = in_chan.valid && in_chan.ready;
  assign push   = accept && in_chan.end_of_text;
  assign pop    = out_valid_r && out_chan.ready;

  assign ch   = in_chan.character;
  assign dig  = (ch >= 8'h30) && (ch <= 8'h39);
  assign dval = ch[3:0];
  assign lc   = ((ch >= 8'h41) && (ch <= 8'h5a)) ? ch + 8'd32 : ch;

  // next parse state for the current character
  always_comb begin
    type_code_nxt = type_code_r;
    file_val_nxt  = file_val_r;
    elem_val_nxt  = elem_val_r;
    size_nxt      = size_r;
    mode_nxt      = mode_r;
    tail_val_nxt  = tail_val_r;
    tail_dig_nxt  = tail_dig_r;
    match_nxt     = match_r;
    tail_len_nxt  = tail_len_r;
    dispatch_en   = 1'b0;

    unique case (mode_r)
      plcap_pkg::MODE_FILE_FIRST: begin
        file_val_nxt = dig ? NW'(dval) : '0;
        mode_nxt     = dig ? plcap_pkg::MODE_FILE_DIGITS : plcap_pkg::MODE_NORMAL;
      end
      plcap_pkg::MODE_FILE_DIGITS: begin
        if (dig) begin
          file_val_nxt = accumulate(file_val_r, dval);
        end else begin
          mode_nxt    = plcap_pkg::MODE_NORMAL;
          dispatch_en = 1'b1;
        end
      end
      plcap_pkg::MODE_ELEM_FIRST: begin
        elem_val_nxt = dig ? NW'(dval) : '0;
        mode_nxt     = dig ? plcap_pkg::MODE_ELEM_DIGITS : plcap_pkg::MODE_NORMAL;
      end
      plcap_pkg::MODE_ELEM_DIGITS: begin
        if (dig) begin
          elem_val_nxt = accumulate(elem_val_r, dval);
        end else begin
          mode_nxt    = plcap_pkg::MODE_NORMAL;
          dispatch_en = 1'b1;
        end
      end
      plcap_pkg::MODE_TAIL_FIRST: begin
        tail_dig_nxt = dig;
        tail_val_nxt = dig ? NW'(dval) : '0;
        mode_nxt     = dig ? plcap_pkg::MODE_TAIL_DIGITS : plcap_pkg::MODE_TAIL_REST;
      end
      plcap_pkg::MODE_TAIL_DIGITS: begin
        if (dig) begin
          tail_val_nxt = accumulate(tail_val_r, dval);
        end else begin
          mode_nxt = plcap_pkg::MODE_TAIL_REST;
        end
      end
      plcap_pkg::MODE_TAIL_REST: begin
      end
      default: begin
        dispatch_en = 1'b1;
      end
    endcase

    // mnemonic matching on every tail character
    if (mode_r == plcap_pkg::MODE_TAIL_FIRST || mode_r == plcap_pkg::MODE_TAIL_DIGITS ||
        mode_r == plcap_pkg::MODE_TAIL_REST) begin
      for (int i = 0; i < plcap_pkg::MnemCount; i++) begin
        if ({1'b0, tail_len_r} >= {2'b0, plcap_pkg::mnem_len(3'(i))} ||
            lc != plcap_pkg::mnem_char(3'(i), tail_len_r[1:0])) begin
          match_nxt[i] = 1'b0;
        end
      end
      if (tail_len_r != 3'd7) begin
        tail_len_nxt = tail_len_r + 3'd1;
      end
    end

    // normal dispatch of type letters and separators
    if (dispatch_en) begin
      unique case (ch)
        "O": begin
          type_code_nxt = plcap_pkg::TYPE_OUTPUT;
          size_nxt      = plcap_pkg::SIZE_WORD;
          file_val_nxt  = '0;
        end
        "I": begin
          type_code_nxt = plcap_pkg::TYPE_INPUT;
          size_nxt      = plcap_pkg::SIZE_WORD;
          file_val_nxt  = NW'(1);
        end
        "S", "B", "T", "C", "R", "N", "F": begin
          case (ch)
            "S":     type_code_nxt = plcap_pkg::TYPE_STATUS;
            "B":     type_code_nxt = plcap_pkg::TYPE_BIT;
            "T":     type_code_nxt = plcap_pkg::TYPE_TIMER;
            "C":     type_code_nxt = plcap_pkg::TYPE_COUNT;
            "R":     type_code_nxt = plcap_pkg::TYPE_CTRL;
            "N":     type_code_nxt = plcap_pkg::TYPE_INT;
            default: type_code_nxt = plcap_pkg::TYPE_FLOAT;
          endcase
          size_nxt     = (ch == "F") ? plcap_pkg::SIZE_FLOAT : plcap_pkg::SIZE_WORD;
          file_val_nxt = '0;
          mode_nxt     = plcap_pkg::MODE_FILE_FIRST;
        end
        ":": begin
          elem_val_nxt = '0;
          mode_nxt     = plcap_pkg::MODE_ELEM_FIRST;
        end
        ".", "/": begin
          mode_nxt     = plcap_pkg::MODE_TAIL_FIRST;
          tail_val_nxt = '0;
          tail_dig_nxt = 1'b0;
          match_nxt    = 7'h7f;
          tail_len_nxt = 3'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // sub-element value, the last matching mnemonic wins
  always_comb begin
    sub = '0;
    if (mode_nxt == plcap_pkg::MODE_TAIL_FIRST || mode_nxt == plcap_pkg::MODE_TAIL_DIGITS ||
        mode_nxt == plcap_pkg::MODE_TAIL_REST) begin
      if (tail_dig_nxt) begin
        sub = to_out(tail_val_nxt);
      end
      for (int i = 0; i < plcap_pkg::MnemCount; i++) begin
        if (match_nxt[i]) begin
          sub = OW'(plcap_pkg::mnem_code(3'(i)));
        end
      end
    end
  end

  // assemble the result request
  always_comb begin
    result.file_type          = type_code_nxt;
    result.file_number        = to_out(file_val_nxt);
    result.element_number     = to_out(elem_val_nxt);
    result.sub_element_number = sub;
    result.data_size          = size_nxt;
  end

  // parse state register, back to reset after each address
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      type_code_r <= plcap_pkg::TYPE_NONE;
      file_val_r  <= '0;
      elem_val_r  <= '0;
      size_r      <= plcap_pkg::SIZE_NONE;
      mode_r      <= plcap_pkg::MODE_NORMAL;
      tail_val_r  <= '0;
      tail_dig_r  <= 1'b0;
      match_r     <= 7'h7f;
      tail_len_r  <= 3'd0;
    end else if (accept) begin
      type_code_r <= type_code_nxt;
      file_val_r  <= file_val_nxt;
      elem_val_r  <= elem_val_nxt;
      size_r      <= size_nxt;
      mode_r      <= mode_nxt;
      tail_val_r  <= tail_val_nxt;
      tail_dig_r  <= tail_dig_nxt;
      match_r     <= match_nxt;
      tail_len_r  <= tail_len_nxt;
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
        if (push) begin
          out_data_r <= result;
        end
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
      skid_data_r  <= result;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.file_type          = out_data_r.file_type;
  assign out_chan.file_number        = out_data_r.file_number;
  assign out_chan.element_number     = out_data_r.element_number;
  assign out_chan.sub_element_number = out_data_r.sub_element_number;
  assign out_chan.data_size          = out_data_r.data_size;

endmodule
`default_nettype wire

// ===== verif/tb_plc_address_text_parser.sv =====
// tb_plc_address_text_parser: self-checking testbench for the address text parser
module tb_plc_address_text_parser;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int STIM_CHARS = 780;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_START = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int SHOWN_FAULTS = 10;
  localparam logic [7:0] ASCII_0 = "0";
  localparam logic [7:0] ASCII_9 = "9";
  localparam logic [15:0] NUM_MAX = 16'hffff;

  // sub-element codes of the mnemonics
  localparam logic [15:0] CODE_ACC = 16'd2;
  localparam logic [15:0] CODE_PRE = 16'd1;
  localparam logic [15:0] CODE_LEN = 16'd1;
  localparam logic [15:0] CODE_POS = 16'd2;
  localparam logic [15:0] CODE_EN = 16'd13;
  localparam logic [15:0] CODE_TT = 16'd14;
  localparam logic [15:0] CODE_DN = 16'd15;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } char_req_t;

  logic clk;
  logic rst_n;

  plcap_in_if  char_if ();
  plcap_out_if res_if ();

  plc_address_text_parser dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (char_if),
    .out_chan(res_if)
  );

  // stimulus and expected results
  char_req_t            char_req_q[$];
  plcap_pkg::result_t   parsed_addr_q[$];
  logic [7:0]           addr_buf[$];
  string                type_letters = "OISBTCRNF";

  // parser state mirror
  logic [7:0]       pm_type;
  logic [15:0]      pm_file;
  logic [15:0]      pm_elem;
  logic [2:0]       pm_size;
  plcap_pkg::mode_t pm_mode;
  logic [15:0]      pm_tail;
  logic             pm_tail_dig;
  logic [6:0]       pm_match;
  logic [2:0]       pm_tlen;

  // handshake bookkeeping
  logic        char_taken;
  logic        recv_hold;
  logic        hold_done;
  int          hold_cycles_left;
  int          send_gap_left;
  int          send_calm_left;
  int          recv_stall_left;
  int          recv_calm_left;
  int          send_roll;
  int          recv_roll;
  char_req_t   next_req;
  plcap_pkg::result_t got;
  plcap_pkg::result_t want;

  // counters
  int          cycle_count;
  int          chars_queued;
  int          addrs_queued;
  int          chars_accepted;
  int          results_checked;
  int          mnem_results;
  int          in_stall_cycles;
  int          fault_count;

  function automatic string mnemonic_text(input int k);
    case (k)
      0:       return "acc";
      1:       return "pre";
      2:       return "len";
      3:       return "pos";
      4:       return "en";
      5:       return "tt";
      default: return "dn";
    endcase
  endfunction

  function automatic logic [15:0] mnemonic_code(input int k);
    case (k)
      0:       return CODE_ACC;
      1:       return CODE_PRE;
      2:       return CODE_LEN;
      3:       return CODE_POS;
      4:       return CODE_EN;
      5:       return CODE_TT;
      default: return CODE_DN;
    endcase
  endfunction

  // decimal multiply-add, saturating
  function automatic logic [15:0] dec_push(input logic [15:0] v, input logic [7:0] c);
    logic [31:0] n;
    n = 32'(v) * 32'd10 + 32'(c - ASCII_0);
    return (n > 32'(NUM_MAX)) ? NUM_MAX : n[15:0];
  endfunction

  task automatic clear_parse();
    pm_type = plcap_pkg::TYPE_NONE;
    pm_file = '0;
    pm_elem = '0;
    pm_size = plcap_pkg::SIZE_NONE;
    pm_mode = plcap_pkg::MODE_NORMAL;
    pm_tail = '0;
    pm_tail_dig = 1'b0;
    pm_match = '1;
    pm_tlen = '0;
  endtask

  task automatic set_file_type(input logic [7:0] code, input logic [2:0] size,
                               input logic takes_number);
    pm_type = code;
    pm_size = size;
    if (takes_number) begin
      pm_file = '0;
      pm_mode = plcap_pkg::MODE_FILE_FIRST;
    end
  endtask

  // normal dispatch of one character
  task automatic take_char(input logic [7:0] c);
    case (c)
      "O": begin
        set_file_type(plcap_pkg::TYPE_OUTPUT, plcap_pkg::SIZE_WORD, 1'b0);
        pm_file = '0;
      end
      "I": begin
        set_file_type(plcap_pkg::TYPE_INPUT, plcap_pkg::SIZE_WORD, 1'b0);
        pm_file = 16'd1;
      end
      "S": set_file_type(plcap_pkg::TYPE_STATUS, plcap_pkg::SIZE_WORD, 1'b1);
      "B": set_file_type(plcap_pkg::TYPE_BIT, plcap_pkg::SIZE_WORD, 1'b1);
      "T": set_file_type(plcap_pkg::TYPE_TIMER, plcap_pkg::SIZE_WORD, 1'b1);
      "C": set_file_type(plcap_pkg::TYPE_COUNT, plcap_pkg::SIZE_WORD, 1'b1);
      "R": set_file_type(plcap_pkg::TYPE_CTRL, plcap_pkg::SIZE_WORD, 1'b1);
      "N": set_file_type(plcap_pkg::TYPE_INT, plcap_pkg::SIZE_WORD, 1'b1);
      "F": set_file_type(plcap_pkg::TYPE_FLOAT, plcap_pkg::SIZE_FLOAT, 1'b1);
      ":": begin
        pm_elem = '0;
        pm_mode = plcap_pkg::MODE_ELEM_FIRST;
      end
      ".", "/": begin
        pm_mode = plcap_pkg::MODE_TAIL_FIRST;
        pm_tail = '0;
        pm_tail_dig = 1'b0;
        pm_match = '1;
        pm_tlen = '0;
      end
      default: ;
    endcase
  endtask

  // knock out mnemonics that no longer fit the tail
  task automatic match_tail(input logic [7:0] c);
    logic [7:0] lc;
    string w;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    for (int k = 0; k < plcap_pkg::MnemCount; k++) begin
      w = mnemonic_text(k);
      if (pm_tlen >= w.len() || lc != 8'(w[pm_tlen])) pm_match[k] = 1'b0;
    end
    if (pm_tlen < 3'd7) pm_tlen++;
  endtask

  // one accepted character; queues the expected result on end of text
  task automatic parse_char(input logic [7:0] c, input logic eot);
    logic dig;
    logic [15:0] sub;
    plcap_pkg::result_t res;
    dig = (c >= ASCII_0 && c <= ASCII_9);
    case (pm_mode)
      plcap_pkg::MODE_FILE_FIRST: begin
        pm_file = dig ? 16'(c - ASCII_0) : '0;
        pm_mode = dig ? plcap_pkg::MODE_FILE_DIGITS : plcap_pkg::MODE_NORMAL;
      end
      plcap_pkg::MODE_FILE_DIGITS: begin
        if (dig) pm_file = dec_push(pm_file, c);
        else begin
          pm_mode = plcap_pkg::MODE_NORMAL;
          take_char(c);
        end
      end
      plcap_pkg::MODE_ELEM_FIRST: begin
        pm_elem = dig ? 16'(c - ASCII_0) : '0;
        pm_mode = dig ? plcap_pkg::MODE_ELEM_DIGITS : plcap_pkg::MODE_NORMAL;
      end
      plcap_pkg::MODE_ELEM_DIGITS: begin
        if (dig) pm_elem = dec_push(pm_elem, c);
        else begin
          pm_mode = plcap_pkg::MODE_NORMAL;
          take_char(c);
        end
      end
      plcap_pkg::MODE_TAIL_FIRST: begin
        pm_tail_dig = dig;
        pm_tail = dig ? 16'(c - ASCII_0) : '0;
        pm_mode = dig ? plcap_pkg::MODE_TAIL_DIGITS : plcap_pkg::MODE_TAIL_REST;
        match_tail(c);
      end
      plcap_pkg::MODE_TAIL_DIGITS: begin
        if (dig) pm_tail = dec_push(pm_tail, c);
        else pm_mode = plcap_pkg::MODE_TAIL_REST;
        match_tail(c);
      end
      plcap_pkg::MODE_TAIL_REST: match_tail(c);
      default: take_char(c);
    endcase
    if (eot) begin
      sub = '0;
      if (pm_mode >= plcap_pkg::MODE_TAIL_FIRST) begin
        if (pm_tail_dig) sub = pm_tail;
        for (int k = 0; k < plcap_pkg::MnemCount; k++) begin
          if (pm_match[k]) sub = mnemonic_code(k);
        end
        if (pm_match != '0) mnem_results++;
      end
      res.file_type = pm_type;
      res.file_number = pm_file;
      res.element_number = pm_elem;
      res.sub_element_number = sub;
      res.data_size = pm_size;
      parsed_addr_q.push_back(res);
      clear_parse();
    end
  endtask

  // stimulus building
  task automatic push_digits(input int n);
    repeat (n) addr_buf.push_back(ASCII_0 + 8'($urandom_range(0, 9)));
  endtask

  function automatic int digit_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 3);
    if (r < 9) return $urandom_range(4, 5);
    return $urandom_range(6, 8);
  endfunction

  task automatic push_tail();
    string w;
    string junk;
    int pick;
    int n;
    junk = "acdelnoprstACDELNOPRST01:";
    addr_buf.push_back($urandom_range(0, 1) ? "." : "/");
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      push_digits($urandom_range(1, 6));
    end else if (pick < 8) begin
      // mnemonic prefix in mixed case
      w = mnemonic_text($urandom_range(0, plcap_pkg::MnemCount - 1));
      n = $urandom_range(1, w.len());
      for (int k = 0; k < n; k++) begin
        addr_buf.push_back($urandom_range(0, 1) ? 8'(w[k]) - 8'd32 : 8'(w[k]));
      end
    end else begin
      n = $urandom_range(0, 4);
      repeat (n) addr_buf.push_back(8'(junk[$urandom_range(0, junk.len() - 1)]));
    end
    if ($urandom_range(0, 4) == 0) begin
      addr_buf.push_back(8'(junk[$urandom_range(0, junk.len() - 1)]));
    end
  endtask

  task automatic send_addr();
    char_req_t req;
    for (int k = 0; k < addr_buf.size(); k++) begin
      req.character = addr_buf[k];
      req.end_of_text = (k == addr_buf.size() - 1);
      char_req_q.push_back(req);
    end
    chars_queued += addr_buf.size();
    addrs_queued++;
    addr_buf.delete();
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) addr_buf.push_back(8'(s[k]));
    send_addr();
  endtask

  // clock and known input levels
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    char_if.valid = 1'b0;
    char_if.character = '0;
    char_if.end_of_text = 1'b0;
    res_if.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  // bookkeeping start values, stimulus, then wait for the drain and report
  initial begin
    int kind;
    logic [7:0] letter;

    char_taken = 1'b0;
    recv_hold = 1'b0;
    hold_done = 1'b0;
    hold_cycles_left = 0;
    send_gap_left = 0;
    send_calm_left = 0;
    recv_stall_left = 0;
    recv_calm_left = 0;
    cycle_count = 0;
    chars_queued = 0;
    addrs_queued = 0;
    chars_accepted = 0;
    results_checked = 0;
    mnem_results = 0;
    in_stall_cycles = 0;
    fault_count = 0;
    clear_parse();

    // directed addresses: single characters, saturation, mnemonics,
    // repeated type letters, odd bytes and an empty tail
    send_text("N");
    send_text(":");
    send_text("F99999:70000/pO");
    send_text("T4:2.acc");
    send_text("R5O");
    addr_buf.push_back("B");
    addr_buf.push_back(8'hff);
    addr_buf.push_back(8'h00);
    addr_buf.push_back("/");
    send_addr();

    // random addresses, mostly well formed
    while (chars_queued < STIM_CHARS) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        repeat ($urandom_range(1, 6)) addr_buf.push_back(8'($urandom));
      end else begin
        if (kind >= 20) begin
          letter = 8'(type_letters[$urandom_range(0, 8)]);
          addr_buf.push_back(letter);
          if (letter != "O" && letter != "I") push_digits(digit_count());
        end
        if ($urandom_range(0, 3) != 0) begin
          addr_buf.push_back(":");
          push_digits(digit_count());
        end
        if ($urandom_range(0, 9) == 0) begin
          addr_buf.push_back(8'(type_letters[$urandom_range(0, 8)]));
          push_digits(digit_count());
        end
        if ($urandom_range(0, 2) != 0) push_tail();
        // broken address: a stray byte somewhere
        if (kind >= 20 && kind < 28) begin
          addr_buf.insert($urandom_range(0, addr_buf.size() - 1), 8'($urandom));
        end
      end
      if (addr_buf.size() == 0) addr_buf.push_back(":");
      send_addr();
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (char_req_q.size() > 0 || char_if.valid) @(posedge clk);
    while (parsed_addr_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d characters in %0d addresses, %0d results checked, %0d by mnemonic",
             chars_accepted, addrs_queued, results_checked, mnem_results);
    $display("run: input held back for %0d cycles while results were held off",
             in_stall_cycles);
    if (fault_count == 0 && parsed_addr_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // character driver
  always @(negedge clk) begin
    if (!rst_n) begin
      char_if.valid <= 1'b0;
    end else if (char_if.valid && !char_taken) begin
      // request still waiting for ready
    end else if (send_gap_left > 0) begin
      send_gap_left--;
      char_if.valid <= 1'b0;
    end else if (char_req_q.size() > 0) begin
      next_req = char_req_q.pop_front();
      char_if.character <= next_req.character;
      char_if.end_of_text <= next_req.end_of_text;
      char_if.valid <= 1'b1;
      if (recv_hold) begin
        send_gap_left = 0;
      end else if (send_calm_left > 0) begin
        send_calm_left--;
        send_gap_left = 0;
      end else begin
        send_roll = $urandom_range(0, 99);
        if (send_roll < 2) send_calm_left = 40;
        if (send_roll < 60) send_gap_left = 0;
        else if (send_roll < 92) send_gap_left = $urandom_range(1, 3);
        else send_gap_left = $urandom_range(6, 20);
      end
    end else begin
      char_if.valid <= 1'b0;
    end
  end

  // long hold-off of the result side, once
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cycles_left > 0) begin
        hold_cycles_left--;
      end else if (!hold_done && chars_accepted >= HOLD_START) begin
        hold_cycles_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
    end
    recv_hold <= (hold_cycles_left > 0);
  end

  // result ready with random stalls
  always @(negedge clk) begin
    if (!rst_n || recv_hold) begin
      res_if.ready <= 1'b0;
    end else if (recv_stall_left > 0) begin
      recv_stall_left--;
      res_if.ready <= 1'b0;
    end else if (recv_calm_left > 0) begin
      recv_calm_left--;
      res_if.ready <= 1'b1;
    end else begin
      recv_roll = $urandom_range(0, 99);
      if (recv_roll < 3) recv_calm_left = 40;
      if (recv_roll < 70) begin
        res_if.ready <= 1'b1;
      end else begin
        recv_stall_left = (recv_roll < 94) ? $urandom_range(0, 3) : $urandom_range(8, 40);
        res_if.ready <= 1'b0;
      end
    end
  end

  // monitor: check results, then predict from accepted characters
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        got.file_type = res_if.file_type;
        got.file_number = res_if.file_number;
        got.element_number = res_if.element_number;
        got.sub_element_number = res_if.sub_element_number;
        got.data_size = res_if.data_size;
        if (parsed_addr_q.size() == 0) begin
          fault_count++;
          if (fault_count <= SHOWN_FAULTS) begin
            $display("unexpected result: type %02h file %0d elem %0d sub %0d size %0d",
                     got.file_type, got.file_number, got.element_number,
                     got.sub_element_number, got.data_size);
          end
        end else begin
          want = parsed_addr_q.pop_front();
          results_checked++;
          if (got.file_type !== want.file_type || got.file_number !== want.file_number ||
              got.element_number !== want.element_number ||
              got.sub_element_number !== want.sub_element_number ||
              got.data_size !== want.data_size) begin
            fault_count++;
            if (fault_count <= SHOWN_FAULTS) begin
              $display("result %0d mismatch: expected type %02h file %0d elem %0d sub %0d size %0d",
                       results_checked, want.file_type, want.file_number,
                       want.element_number, want.sub_element_number, want.data_size);
              $display("result %0d mismatch: actual   type %02h file %0d elem %0d sub %0d size %0d",
                       results_checked, got.file_type, got.file_number,
                       got.element_number, got.sub_element_number, got.data_size);
            end
          end
        end
      end
      if (char_if.valid && char_if.ready) begin
        parse_char(char_if.character, char_if.end_of_text);
        chars_accepted++;
      end
      if (char_if.valid && !char_if.ready && recv_hold) in_stall_cycles++;
    end
    char_taken <= rst_n && char_if.valid && char_if.ready;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
